[design/sidasc_pkg.sv]
package sidasc_pkg;

   // ASCII codes of the emitted characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // one BCD digit, and how many magnitude bits each conversion cycle consumes
   localparam int DIGIT_BITS     = 4;
   localparam int BITS_PER_CYCLE = 4;

   // decimal digits needed for a magnitude of up to 2**(value_bits-1)
   // (0.30103 approximates log10(2))
   function automatic int max_digits(input int value_bits);
      return ((value_bits - 1) * 30103) / 100000 + 1;
   endfunction

endpackage

[design/sidasc_if.sv]
interface sidasc_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sidasc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

[design/sidasc_front.sv]
module sidasc_front
   import sidasc_pkg::*;
#(
   parameter int VALUE_BITS = 32,
   parameter int NDIG       = 10,
   parameter int IDX_BITS   = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   sidasc_req_if.sink                     req_ch,
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic [IDX_BITS+NDIG*DIGIT_BITS:0] push_data
);

   localparam int BCD_BITS = NDIG * DIGIT_BITS;
   localparam int ITERS    = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int PAD_BITS = ITERS * BITS_PER_CYCLE;
   localparam int CNT_BITS = (ITERS > 1) ? $clog2(ITERS) : 1;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [PAD_BITS-1:0]   mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag_abs;
   logic [IDX_BITS-1:0]   top_idx;

   // shift four magnitude bits into the BCD register, add-3 before each shift
   function automatic logic [BCD_BITS-1:0] dabble4(
      input logic [BCD_BITS-1:0]       bcd_i,
      input logic [BITS_PER_CYCLE-1:0] bits_i
   );
      logic [BCD_BITS-1:0] acc;
      acc = bcd_i;
      for (int s = 0; s < BITS_PER_CYCLE; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (acc[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
               acc[d*DIGIT_BITS +: DIGIT_BITS] = acc[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end
         end
         acc = {acc[BCD_BITS-2:0], bits_i[BITS_PER_CYCLE-1-s]};
      end
      return acc;
   endfunction

   // sign and magnitude; the most negative value maps to its unsigned magnitude
   assign raw     = req_ch.value;
   assign mag_abs = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

   // locate the most significant nonzero digit, zero gives digit 0
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            top_idx = IDX_BITS'(i);
         end
      end
   end

   assign req_ch.ready = (state_ff == F_IDLE);
   assign push_valid   = (state_ff == F_PUSH);
   assign push_data    = {neg_ff, top_idx, bcd_ff};

   // intake, conversion and hand-off sequencing
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_ch.valid) begin
               mag_in   = PAD_BITS'(mag_abs);
               neg_in   = raw[VALUE_BITS-1];
               bcd_in   = '0;
               cnt_in   = CNT_BITS'(ITERS - 1);
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            bcd_in = dabble4(bcd_ff, mag_ff[PAD_BITS-1 -: BITS_PER_CYCLE]);
            mag_in = mag_ff << BITS_PER_CYCLE;
            if (cnt_ff == '0) begin
               state_in = F_PUSH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

[design/sidasc_queue.sv]
module sidasc_queue #(
   parameter int WIDTH = 45
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/sidasc_back.sv]
module sidasc_back
   import sidasc_pkg::*;
#(
   parameter int NDIG     = 10,
   parameter int IDX_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  logic [IDX_BITS+NDIG*DIGIT_BITS:0] pop_data,
   sidasc_rsp_if.source                      rsp_ch
);

   localparam int BCD_BITS = NDIG * DIGIT_BITS;

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_SIGN  = 3'b010,
      B_DIGIT = 3'b100
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [BCD_BITS-1:0]   digits_ff, digits_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  entry_neg;
   logic [IDX_BITS-1:0]   entry_top;
   logic [BCD_BITS-1:0]   entry_digits;
   logic                  emit;
   logic                  emit_last;
   logic [7:0]            next_char;

   assign {entry_neg, entry_top, entry_digits} = pop_data;

   // one character leaves whenever the output register is free or being taken
   assign emit      = (state_ff != B_IDLE) && (!out_valid_ff || rsp_ch.ready);
   assign emit_last = (state_ff == B_DIGIT) && (idx_ff == '0);
   assign next_char = (state_ff == B_SIGN) ? CHAR_MINUS
                    : CHAR_ZERO + {4'b0000, digits_ff[idx_ff*DIGIT_BITS +: DIGIT_BITS]};
   assign pop_ready = (state_ff == B_IDLE) || (emit && emit_last);

   // emission sequencing, next entry loads as the last character leaves
   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      idx_in    = idx_ff;
      if (pop_valid && pop_ready) begin
         digits_in = entry_digits;
         idx_in    = entry_top;
         state_in  = entry_neg ? B_SIGN : B_DIGIT;
      end else if (emit) begin
         unique case (state_ff)
            B_SIGN:  state_in = B_DIGIT;
            B_DIGIT: begin
               if (emit_last) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            default: state_in = B_IDLE;
         endcase
      end
   end

   // output register: load on emit, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         char_in      = next_char;
         last_in      = emit_last;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.character = char_ff;
   assign rsp_ch.last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      digits_ff <= digits_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

endmodule

[design/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal ASCII text.
// req_ch carries one VALUE_BITS two's complement value per transaction.
// rsp_ch returns its text one character per transaction, most significant
// first: '-' for a negative value, then the digits without leading zeros,
// with last set on the final digit. Zero gives the single character '0'.
// The front converts the magnitude to BCD four bits per cycle and then
// hands the result to the queue; it accepts no new value until that
// hand-off is done. The back sends one character per cycle while the
// receiver takes them, up to 11 characters at 32 bits. A two-entry queue
// separates front and back.
// Reset clears the sequencers, empties the queue and drops rsp_ch.valid.
// When the receiver stalls, the output register holds its character, the
// queue fills, and then req_ch.ready stays low until space frees up.
module signed_int_to_decimal_ascii
   import sidasc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   sidasc_req_if.sink   req_ch,
   sidasc_rsp_if.source rsp_ch
);

   localparam int NDIG       = max_digits(VALUE_BITS);
   localparam int IDX_BITS   = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int ENTRY_BITS = 1 + IDX_BITS + NDIG * DIGIT_BITS;

   logic                  push_valid;
   logic                  push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   sidasc_front #(
      .VALUE_BITS (VALUE_BITS),
      .NDIG       (NDIG),
      .IDX_BITS   (IDX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sidasc_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sidasc_back #(
      .NDIG     (NDIG),
      .IDX_BITS (IDX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

[tb/signed_int_to_decimal_ascii_tb.sv]
module signed_int_to_decimal_ascii_tb
   import sidasc_pkg::*;
;

   localparam int VALUE_BITS = 32;
   localparam logic [VALUE_BITS-1:0] RADIX = 10;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 30;
   localparam int IDLE_PERCENT = 8;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   sidasc_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   sidasc_rsp_if rsp_bus ();

   signed_int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // characters still owed by the block, oldest first
   text_char_type pending_text[$];

   int  errors = 0;
   int  values_sent = 0;
   int  negatives_sent = 0;
   int  chars_checked = 0;
   int  quiet_cycles = 0;
   bit  sender_idling = 1'b1;
   bit  receiver_idling = 1'b1;

   // clock: 8 time units
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // append the decimal text of one value to the pending characters
   function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
      logic [7:0]            digits[$];
      text_char_type         entry;
      negative  = value[VALUE_BITS-1];
      magnitude = negative ? (~value + 1'b1) : value;
      do begin
         digits.push_front(CHAR_ZERO + 8'(magnitude % RADIX));
         magnitude = magnitude / RADIX;
      end while (magnitude != 0);
      if (negative) begin
         entry.character = CHAR_MINUS;
         entry.last = 1'b0;
         pending_text.push_back(entry);
      end
      foreach (digits[i]) begin
         entry.character = digits[i];
         entry.last = (i == digits.size() - 1);
         pending_text.push_back(entry);
      end
   endfunction

   // pick a value: raw bits, a random digit count, near a power of ten, or tiny
   function automatic logic [VALUE_BITS-1:0] random_value();
      longint unsigned magnitude;
      longint unsigned span;
      bit              negative;
      int              mode;
      mode = $urandom_range(0, 3);
      negative = 1'($urandom_range(0, 1));
      span = 1;
      case (mode)
         0: begin
            return VALUE_BITS'($urandom());
         end
         1: begin
            repeat ($urandom_range(1, 10)) span = span * 10;
            magnitude = {$urandom(), $urandom()} % span;
         end
         2: begin
            repeat ($urandom_range(0, 9)) span = span * 10;
            magnitude = span + $urandom_range(0, 2) - 1;
         end
         default: begin
            magnitude = 64'($urandom_range(0, 20));
         end
      endcase
      if (magnitude > 64'd2147483648)
         magnitude = magnitude % 64'd2147483648;
      if (!negative && magnitude == 64'd2147483648)
         magnitude = magnitude - 1;
      return negative ? VALUE_BITS'(-magnitude) : VALUE_BITS'(magnitude);
   endfunction

   // offer one value, hold it until accepted, then record its text
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      while (sender_idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      predict_text(value);
      values_sent++;
      if (value[VALUE_BITS-1])
         negatives_sent++;
   endtask

   // drop valid and hold off until every owed character has arrived
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_text.size() != 0);
   endtask

   task automatic test_directed();
      logic [VALUE_BITS-1:0] corner[$];
      corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd101, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'd1000000000, -32'sd1000000000, 32'd999999999, -32'sd999999999,
                 32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd2000000000};
      foreach (corner[i])
         send_value(corner[i]);
   endtask

   // single values with the block fully drained between them
   task automatic test_drained_pauses();
      repeat (8) begin
         send_value(random_value());
         wait_for_drain();
      end
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      repeat (60) send_value(random_value());
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
   endtask

   task automatic test_random();
      repeat (392) send_value(random_value());
   endtask

   // receiver: stall now and then
   always @(posedge clock) begin
      rsp_bus.ready <= !receiver_idling || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // compare each character transaction with the oldest owed character
   always @(posedge clock) begin
      text_char_type owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_text.size() == 0) begin
            errors++;
            $display("%0t: unexpected character: expected none actual %h last %b",
                     $time, rsp_bus.character, rsp_bus.last);
         end else begin
            owed = pending_text.pop_front();
            chars_checked++;
            if (rsp_bus.character !== owed.character) begin
               errors++;
               $display("%0t: character mismatch: expected %h actual %h",
                        $time, owed.character, rsp_bus.character);
            end
            if (rsp_bus.last !== owed.last) begin
               errors++;
               $display("%0t: last flag mismatch: expected %b actual %b",
                        $time, owed.last, rsp_bus.last);
            end
         end
      end
   end

   // watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_drained_pauses();
      test_back_to_back();
      test_random();

      // drain, then give the block time to show any stray character
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d negative) into %0d checked characters,",
               values_sent, negatives_sent, chars_checked);
      $display("covering zero, both extremes, powers of ten, drained and back-to-back runs.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
design/sidasc_pkg.sv
design/sidasc_if.sv
design/sidasc_front.sv
design/sidasc_queue.sv
design/sidasc_back.sv
design/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
